// ===== rtl/core/rpnalu_pkg.sv =====
// Shared types, codes and constants for the RPN operand stack calculator.
package rpnalu_pkg;

   localparam int DATA_W          = 32;
   localparam int ITER_W          = $clog2(DATA_W + 1);
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_OP    = 2'd1,
      REQ_POP   = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FEW   = 3'd1,
      ST_BADOP = 3'd2,
      ST_DIV0  = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_RD,
      S_RD_B,
      S_RD_A,
      S_EXEC,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

endpackage

// ===== rtl/core/rpnalu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rpnalu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rpnalu_alu.sv =====
// Iterative ALU: one shared adder serves add, subtract, shift-add multiply and restoring divide.
module rpnalu_alu (
   input  logic                                clock,
   input  logic                                reset,
   input  rpnalu_pkg::alu_ctrl_type            ctrl,
   input  logic [rpnalu_pkg::DATA_W-1:0]       opnd_a,
   input  logic [rpnalu_pkg::DATA_W-1:0]       opnd_b,
   output rpnalu_pkg::alu_stat_type            stat,
   output logic [rpnalu_pkg::DATA_W-1:0]       result
);
   import rpnalu_pkg::*;

   localparam int SUM_W = DATA_W + 2;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   alu_op_type          op_ff, op_in;
   logic                neg_ff, neg_in;
   logic [ITER_W-1:0]   cnt_ff, cnt_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic [DATA_W-1:0]   opnd_ff, opnd_in;
   logic [DATA_W-1:0]   q_ff, q_in;
   logic [DATA_W-1:0]   res_ff, res_in;

   logic [SUM_W-1:0]    add_x, add_y, sum;
   logic                add_cin;
   logic [DATA_W:0]     rem_sh;
   logic                borrow;
   logic [DATA_W-1:0]   mag_a, mag_b;

   assign rem_sh = {acc_ff, q_ff[DATA_W-1]};
   assign sum    = add_x + add_y + SUM_W'(add_cin);
   assign borrow = sum[SUM_W-1];
   assign mag_a  = opnd_a[DATA_W-1] ? (~opnd_a + DATA_W'(1)) : opnd_a;
   assign mag_b  = opnd_b[DATA_W-1] ? (~opnd_b + DATA_W'(1)) : opnd_b;

   // operand selection for the shared adder
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_cin = 1'b0;
      if (busy_ff) begin
         unique case (op_ff)
            ALU_MUL: begin
               add_x = {2'b00, acc_ff};
               add_y = q_ff[0] ? {2'b00, opnd_ff} : '0;
            end
            ALU_DIV: begin
               add_x   = {1'b0, rem_sh};
               add_y   = ~{2'b00, opnd_ff};
               add_cin = 1'b1;
            end
            default: begin
               add_x = '0;
            end
         endcase
      end else begin
         unique case (ctrl.op)
            ALU_ADD: begin
               add_x = {2'b00, opnd_a};
               add_y = {2'b00, opnd_b};
            end
            ALU_SUB: begin
               add_x   = {2'b00, opnd_a};
               add_y   = ~{2'b00, opnd_b};
               add_cin = 1'b1;
            end
            default: begin
               add_x = '0;
            end
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opnd_in = opnd_ff;
      q_in    = q_ff;
      res_in  = res_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff - ITER_W'(1);
         unique case (op_ff)
            ALU_MUL: begin
               acc_in  = sum[DATA_W-1:0];
               opnd_in = {opnd_ff[DATA_W-2:0], 1'b0};
               q_in    = {1'b0, q_ff[DATA_W-1:1]};
            end
            ALU_DIV: begin
               acc_in = borrow ? rem_sh[DATA_W-1:0] : sum[DATA_W-1:0];
               q_in   = {q_ff[DATA_W-2:0], ~borrow};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (op_ff == ALU_MUL) begin
               res_in = acc_in;
            end else begin
               res_in = neg_ff ? (~q_in + DATA_W'(1)) : q_in;
            end
         end
      end else if (ctrl.start) begin
         op_in = ctrl.op;
         unique case (ctrl.op)
            ALU_ADD, ALU_SUB: begin
               res_in  = sum[DATA_W-1:0];
               done_in = 1'b1;
            end
            ALU_MUL: begin
               acc_in  = '0;
               opnd_in = opnd_a;
               q_in    = opnd_b;
               cnt_in  = ITER_W'(DATA_W);
               busy_in = 1'b1;
            end
            ALU_DIV: begin
               acc_in  = '0;
               opnd_in = mag_b;
               q_in    = mag_a;
               neg_in  = opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
               cnt_in  = ITER_W'(DATA_W);
               busy_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      opnd_ff <= opnd_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctrl.start)
      else $error("alu started while busy");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("alu done while still iterating");

   a_iter_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("alu iteration count ran out while busy");

endmodule

// ===== rtl/core/rpn_operand_stack_alu_top.sv =====
// Top level of the RPN operand stack calculator: request sequencer, stack RAM and ALU.
//
// One request is handled at a time; req_stall is high while a request is in progress.
// A push, a clear, or a request rejected for stack depth or operator goes straight to the
// response state; a pop first reads the top entry; an operator reads both operands from the
// stack RAM, then reports a division by zero or runs the shared ALU, * and / in its 32-step
// shift-add and restoring-divide steps. The result waits in an output register, so the block
// takes the next request while it is stalled; a further result is held back until that
// register is free. The stack is a RAM of STACK_DEPTH entries with a top count; its
// contents are undefined after reset and only entries below the count are ever read.
module rpn_operand_stack_alu_top #(
   parameter int STACK_DEPTH = rpnalu_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic signed [rpnalu_pkg::DATA_W-1:0] req_push_value,
   input  logic [7:0]                    req_op_char,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic signed [rpnalu_pkg::DATA_W-1:0] rsp_pop_data,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_is_empty
);
   import rpnalu_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   seq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DATA_W-1:0]  b_ff, b_in;
   alu_op_type         op_ff, op_in;
   logic               pend_ok_ff, pend_ok_in;
   logic [DATA_W-1:0]  pend_data_ff, pend_data_in;
   status_type         pend_status_ff, pend_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               accept;
   logic               full;
   logic               op_known;
   alu_op_type         op_dec;
   logic [CNT_W-1:0]   count_m1, count_m2;

   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0]  wr_data, rd_data;

   alu_ctrl_type       alu_ctrl;
   alu_stat_type       alu_stat;
   logic [DATA_W-1:0]  alu_result;

   rpnalu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rpnalu_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .opnd_a (rd_data),
      .opnd_b (b_ff),
      .stat   (alu_stat),
      .result (alu_result)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign count_m1  = count_ff - CNT_W'(1);
   assign count_m2  = count_ff - CNT_W'(2);

   always_comb begin
      op_known = 1'b1;
      op_dec   = ALU_ADD;
      unique case (req_op_char)
         CHAR_PLUS:  op_dec = ALU_ADD;
         CHAR_MINUS: op_dec = ALU_SUB;
         CHAR_STAR:  op_dec = ALU_MUL;
         CHAR_SLASH: op_dec = ALU_DIV;
         default:    op_known = 1'b0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      b_in           = b_ff;
      op_in          = op_ff;
      pend_ok_in     = pend_ok_ff;
      pend_data_in   = pend_data_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_ok_in      = rsp_ok_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_empty_in   = rsp_empty_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[ADDR_W-1:0];
      wr_data        = req_push_value;
      rd_en          = 1'b0;
      rd_addr        = count_m1[ADDR_W-1:0];
      alu_ctrl.start = 1'b0;
      alu_ctrl.op    = op_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_ok_in     = 1'b0;
               pend_data_in   = '0;
               pend_status_in = ST_OK;
               state_in       = S_DONE;
               unique case (req_kind_type'(req_type))
                  REQ_PUSH: begin
                     if (full) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                        pend_ok_in = 1'b1;
                     end
                  end
                  REQ_OP: begin
                     if (count_ff < CNT_W'(2)) begin
                        pend_status_in = ST_FEW;
                     end else if (!op_known) begin
                        pend_status_in = ST_BADOP;
                     end else begin
                        op_in    = op_dec;
                        rd_en    = 1'b1;
                        state_in = S_RD_B;
                     end
                  end
                  REQ_POP: begin
                     if (count_ff == '0) begin
                        pend_status_in = ST_FEW;
                     end else begin
                        rd_en    = 1'b1;
                        count_in = count_m1;
                        state_in = S_POP_RD;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in   = '0;
                     pend_ok_in = 1'b1;
                  end
               endcase
            end
         end
         S_POP_RD: begin
            pend_data_in = rd_data;
            pend_ok_in   = 1'b1;
            state_in     = S_DONE;
         end
         S_RD_B: begin
            b_in     = rd_data;
            rd_en    = 1'b1;
            rd_addr  = count_m2[ADDR_W-1:0];
            state_in = S_RD_A;
         end
         S_RD_A: begin
            if ((op_ff == ALU_DIV) && (b_ff == '0)) begin
               pend_status_in = ST_DIV0;
               state_in       = S_DONE;
            end else begin
               alu_ctrl.start = 1'b1;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            if (alu_stat.done) begin
               wr_en      = 1'b1;
               wr_addr    = count_m2[ADDR_W-1:0];
               wr_data    = alu_result;
               count_in   = count_m1;
               pend_ok_in = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = pend_ok_ff;
               rsp_data_in   = pend_data_ff;
               rsp_status_in = pend_status_ff;
               rsp_empty_in  = (count_ff == '0);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_ff           <= b_in;
      op_ff          <= op_in;
      pend_ok_ff     <= pend_ok_in;
      pend_data_ff   <= pend_data_in;
      pend_status_ff <= pend_status_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_pop_data = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_is_empty = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ok_ff == (rsp_status_ff == ST_OK)))
      else $error("ok flag disagrees with status");

   a_data_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff != '0)) |-> rsp_ok_ff)
      else $error("pop data on a failed request");

   a_alu_done_in_exec: assert property (@(posedge clock) disable iff (reset)
      alu_stat.done |-> (state_ff == S_EXEC))
      else $error("alu result outside execute state");

endmodule
